[hw/rtl/sba_pkg.sv]
`timescale 1ns / 1ps

package sba_pkg;

    // table geometry
    localparam int SLOTS  = 16;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;
    localparam int ADDR_W = 17;

    // field widths
    localparam int OP_W     = 3;
    localparam int ID_W     = 8;
    localparam int LEN_W    = 8;
    localparam int STS_W    = 3;
    localparam int CFG_IX_W = 2;
    localparam int CFG_D_W  = 16;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD = 8'd128;
    localparam logic [8:0]       CHECK_BYTES = 9'd2;

    // operations
    localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
    localparam logic [OP_W-1:0] OP_OPEN    = 3'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEANUP = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    // result status
    localparam logic [STS_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STS_W-1:0] ST_NEW       = 3'd1;
    localparam logic [STS_W-1:0] ST_NONE_FREE = 3'd2;
    localparam logic [STS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STS_W-1:0] ST_TOO_LARGE = 3'd4;
    localparam logic [STS_W-1:0] ST_MET       = 3'd5;
    localparam logic [STS_W-1:0] ST_SHORT     = 3'd6;

    // config register indexes
    localparam logic [CFG_IX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_BYTES = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_COUNT = 2'd2;
    localparam logic [CFG_IX_W-1:0] CFG_MINF  = 2'd3;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic sweep_start;
        logic sweep_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_cleanup;
        logic scan_done;
        logic sweep_done;
    } sts_t;

endpackage

[hw/rtl/sba_dp.sv]
`timescale 1ns / 1ps

module sba_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [sba_pkg::CFG_IX_W-1:0]  cfg_index,
    input  logic [sba_pkg::CFG_D_W-1:0]   cfg_data,
    input  logic [sba_pkg::OP_W-1:0]      operation,
    input  logic [sba_pkg::ID_W-1:0]      client_id,
    input  logic [sba_pkg::IDX_W-1:0]     entry_index,
    input  logic [sba_pkg::LEN_W-1:0]     payload_length,
    input  sba_pkg::cmd_t                 cmd,
    output sba_pkg::sts_t                 sts,
    output logic [sba_pkg::STS_W-1:0]     status,
    output logic [sba_pkg::ADDR_W-1:0]    block_address,
    output logic [sba_pkg::IDX_W-1:0]     block_number,
    output logic                          table_changed,
    output logic [sba_pkg::CNT_W-1:0]     free_count
);
    import sba_pkg::*;

    logic [ID_W-1:0]    owner_reg [SLOTS];
    logic [ID_W-1:0]    list_reg  [SLOTS];

    logic [15:0]        base_reg;
    logic [7:0]         bytes_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   minf_reg;

    logic [OP_W-1:0]    op_reg;
    logic [ID_W-1:0]    client_reg;
    logic [IDX_W-1:0]   entry_reg;
    logic [LEN_W-1:0]   len_reg;

    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               list_vld_reg;
    logic [IDX_W-1:0]   list_idx_reg;
    logic               own_vld_reg;
    logic [IDX_W-1:0]   own_idx_reg;
    logic               free_vld_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               chg_reg;

    logic [STS_W-1:0]   status_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [IDX_W-1:0]   num_reg;
    logic               changed_reg;
    logic [CNT_W-1:0]   freec_reg;

    logic [CNT_W-1:0]   n_use;
    logic [IDX_W-1:0]   rd_idx;
    logic [ID_W-1:0]    own_rd;
    logic [ID_W-1:0]    lst_rd;
    logic               owner_active;
    logic               free_now;
    logic               client_zero;
    logic               too_large;
    logic               trivial;

    logic [STS_W-1:0]   status_next;
    logic [IDX_W-1:0]   sel_idx;
    logic               addr_en;
    logic [IDX_W-1:0]   num_next;
    logic               changed_next;
    logic [CNT_W-1:0]   freec_next;
    logic [8:0]         span;
    logic [12:0]        offset;
    logic [ADDR_W-1:0]  addr_calc;
    logic               claim;

    assign n_use       = (count_reg > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : count_reg;
    assign rd_idx      = idx_reg[IDX_W-1:0];
    assign own_rd      = owner_reg[rd_idx];
    assign lst_rd      = list_reg[rd_idx];
    assign client_zero = (client_reg == '0);
    assign too_large   = (len_reg > MAX_PAYLOAD);

    // owner kept if it matches any nonzero client in the slots in use
    always_comb
    begin
        owner_active = 1'b0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (list_reg[k] != '0 && list_reg[k] == own_rd && CNT_W'(k) < n_use)
                owner_active = 1'b1;
        end
    end

    assign free_now = (own_rd != '0) && !owner_active;

    always_comb
    begin
        case (op_reg)
            OP_OPEN:    trivial = client_zero;
            OP_LOOKUP:  trivial = client_zero || too_large;
            OP_CLEANUP: trivial = 1'b0;
            default:    trivial = 1'b1;
        endcase
    end

    assign sts.is_cleanup = (op_reg == OP_CLEANUP);
    assign sts.scan_done  = trivial || (idx_reg >= n_use);
    assign sts.sweep_done = (idx_reg >= n_use) || (cnt_reg >= minf_reg);

    assign claim = (op_reg == OP_OPEN) && !client_zero && !own_vld_reg && free_vld_reg;

    // result decode
    always_comb
    begin
        status_next  = ST_FOUND;
        sel_idx      = own_idx_reg;
        addr_en      = 1'b0;
        changed_next = 1'b0;
        freec_next   = '0;
        case (op_reg)
            OP_LOAD:
            begin
                changed_next = 1'b1;
            end
            OP_OPEN:
            begin
                if (client_zero)
                    status_next = ST_NOT_FOUND;
                else if (own_vld_reg)
                    addr_en = 1'b1;
                else if (free_vld_reg)
                begin
                    status_next  = ST_NEW;
                    sel_idx      = free_idx_reg;
                    addr_en      = 1'b1;
                    changed_next = 1'b1;
                end
                else
                    status_next = ST_NONE_FREE;
            end
            OP_LOOKUP:
            begin
                if (too_large)
                    status_next = ST_TOO_LARGE;
                else if (!client_zero && own_vld_reg)
                    addr_en = 1'b1;
                else
                    status_next = ST_NOT_FOUND;
            end
            OP_CLEANUP:
            begin
                status_next  = (cnt_reg >= minf_reg) ? ST_MET : ST_SHORT;
                freec_next   = cnt_reg;
                changed_next = chg_reg;
            end
            OP_CLEAR:
            begin
                changed_next = 1'b1;
            end
            default:
            begin
                status_next = ST_FOUND;
            end
        endcase
    end

    assign span      = {1'b0, bytes_reg} + CHECK_BYTES;
    assign offset    = 13'(span) * 13'(sel_idx);
    assign addr_calc = {1'b0, base_reg} + ADDR_W'(offset);
    assign num_next  = addr_en ? sel_idx : ((op_reg == OP_LOAD) ? entry_reg : '0);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            bytes_reg <= 8'd128;
            count_reg <= CNT_W'(16);
            minf_reg  <= CNT_W'(2);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BASE:  base_reg  <= cfg_data;
                CFG_BYTES: bytes_reg <= cfg_data[7:0];
                CFG_COUNT: count_reg <= cfg_data[CNT_W-1:0];
                CFG_MINF:  minf_reg  <= cfg_data[CNT_W-1:0];
                default:   base_reg  <= base_reg;
            endcase
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= operation;
            client_reg <= client_id;
            entry_reg  <= entry_index;
            len_reg    <= payload_length;
        end
    end

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            cnt_reg      <= '0;
            list_vld_reg <= 1'b0;
            list_idx_reg <= '0;
            own_vld_reg  <= 1'b0;
            own_idx_reg  <= '0;
            free_vld_reg <= 1'b0;
            free_idx_reg <= '0;
            chg_reg      <= 1'b0;
        end
        else if (cmd.capture)
        begin
            idx_reg      <= '0;
            cnt_reg      <= '0;
            list_vld_reg <= 1'b0;
            own_vld_reg  <= 1'b0;
            free_vld_reg <= 1'b0;
            chg_reg      <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (lst_rd == '0 && !list_vld_reg)
            begin
                list_vld_reg <= 1'b1;
                list_idx_reg <= rd_idx;
            end
            if (own_rd == client_reg && !own_vld_reg)
            begin
                own_vld_reg <= 1'b1;
                own_idx_reg <= rd_idx;
            end
            if (own_rd == '0)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (!free_vld_reg)
                begin
                    free_vld_reg <= 1'b1;
                    free_idx_reg <= rd_idx;
                end
            end
        end
        else if (cmd.sweep_start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.sweep_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (free_now)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                chg_reg <= 1'b1;
            end
        end
    end

    // owner table and client list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                owner_reg[i] <= '0;
                list_reg[i]  <= '0;
            end
        end
        else if (cmd.finish && op_reg == OP_CLEAR)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                owner_reg[i] <= '0;
                list_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.finish && op_reg == OP_LOAD)
                owner_reg[entry_reg] <= client_reg;
            if (cmd.finish && claim)
                owner_reg[free_idx_reg] <= client_reg;
            if (cmd.finish && op_reg == OP_OPEN && !client_zero && list_vld_reg)
                list_reg[list_idx_reg] <= client_reg;
            if (cmd.sweep_step && free_now)
                owner_reg[rd_idx] <= '0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg  <= status_next;
            addr_reg    <= addr_en ? addr_calc : '0;
            num_reg     <= num_next;
            changed_reg <= changed_next;
            freec_reg   <= freec_next;
        end
    end

    assign status        = status_reg;
    assign block_address = addr_reg;
    assign block_number  = num_reg;
    assign table_changed = changed_reg;
    assign free_count    = freec_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= CNT_W'(SLOTS))
        else $error("walk index past table");

    a_sweep_frees_only_short: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep_step && free_now) |-> (cnt_reg < minf_reg))
        else $error("block freed after minimum met");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(SLOTS))
        else $error("free count past table");

endmodule

[hw/rtl/sba_ctrl.sv]
`timescale 1ns / 1ps

module sba_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    input  sba_pkg::sts_t  sts,
    output sba_pkg::cmd_t  cmd
);
    import sba_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_SWEEP  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        cmd.capture     = req_valid && !req_stall;
        cmd.scan_step   = (state_reg == S_SCAN) && !sts.scan_done;
        cmd.sweep_start = (state_reg == S_SCAN) && sts.scan_done && sts.is_cleanup;
        cmd.sweep_step  = (state_reg == S_SWEEP) && !sts.sweep_done;
        cmd.finish      = (state_reg == S_FINISH) && (!out_valid_reg || !rsp_stall);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (cmd.capture)
                    state_next = S_SCAN;
            S_SCAN:
                if (sts.scan_done)
                    state_next = sts.is_cleanup ? S_SWEEP : S_FINISH;
            S_SWEEP:
                if (sts.sweep_done)
                    state_next = S_FINISH;
            S_FINISH:
                if (cmd.finish)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (!rsp_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> rsp_valid)
        else $error("result not presented after finish");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && rsp_stall))
        else $error("pending result overwritten");

    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> rsp_valid)
        else $error("stalled result dropped");

endmodule

[hw/rtl/storage_block_allocator.sv]
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// req       req_valid / req_stall    operation, client_id, entry_index, payload_length
// rsp       rsp_valid / rsp_stall    status, block_address, block_number,
//                                    table_changed, free_count
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item in flight; n = min(active_block_count, 16). Open and lookup scan the
// n slots in use, one table entry a cycle, except for client zero or an oversized
// payload; cleanup scans, then sweeps until the minimum is met or the slots end.
// Async active-low reset empties the owner table and client list and loads
// the config defaults. A stalled result sits in the output register; the
// next item is accepted meanwhile and waits in its finish state.

module storage_block_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sba_pkg::CFG_IX_W-1:0]   cfg_index,
    input  logic [sba_pkg::CFG_D_W-1:0]    cfg_data,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [sba_pkg::OP_W-1:0]       operation,
    input  logic [sba_pkg::ID_W-1:0]       client_id,
    input  logic [sba_pkg::IDX_W-1:0]      entry_index,
    input  logic [sba_pkg::LEN_W-1:0]      payload_length,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [sba_pkg::STS_W-1:0]      status,
    output logic [sba_pkg::ADDR_W-1:0]     block_address,
    output logic [sba_pkg::IDX_W-1:0]      block_number,
    output logic                           table_changed,
    output logic [sba_pkg::CNT_W-1:0]      free_count
);
    import sba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // config writes are registered and always taken
    assign cfg_ready = 1'b1;

    // sequencer: idle -> scan -> (sweep for cleanup) -> finish
    sba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // tables, config, walk registers, address calc and result register
    sba_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .operation      (operation),
        .client_id      (client_id),
        .entry_index    (entry_index),
        .payload_length (payload_length),
        .cmd            (cmd),
        .sts            (sts),
        .status         (status),
        .block_address  (block_address),
        .block_number   (block_number),
        .table_changed  (table_changed),
        .free_count     (free_count)
    );

endmodule
